// ----- hdl/sfr_pkg.sv -----
package sfr_pkg;

    localparam int MAX_LEN   = 8;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CFG_W     = MAX_LEN * BYTE_W;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH,
        ST_DONE
    } sfr_state_t;

    function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v > LEN_W'(MAX_LEN))
            r = CNT_W'(MAX_LEN);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

// ----- hdl/sfr_in_if.sv -----
interface sfr_in_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_in;
    logic              final_char;

    modport source (output valid, char_in, final_char, input ready);
    modport sink   (input valid, char_in, final_char, output ready);
endinterface

// ----- hdl/sfr_out_if.sv -----
interface sfr_out_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_out;
    logic              char_valid;
    logic              string_end;

    modport source (output valid, char_out, char_valid, string_end, input ready);
    modport sink   (input valid, char_out, char_valid, string_end, output ready);
endinterface

// ----- hdl/stream_find_replace_unit.sv -----
// steps: take a byte in idle, scan (drop bytes that cannot start a match, then decide), emit the
// replacement bytes, on a final byte flush the held bytes, then close the byte in the done state
// a result waits in a staging register until the next result is made or the done state closes
// the byte; the closed result then moves on to the output register once that register is free
// a new byte is taken only in idle, so the block does not take a byte before it is through with
// the last one; output stalls hold the single emit path into the staging register
// reset: rst_n clears the sequencer, hold count, output stage and all four registers
module stream_find_replace_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  sfr_pkg::cfg_idx_t                   cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]           cfg_data,
    sfr_in_if.sink                              in_ch,
    sfr_out_if.source                           out_ch
);
    import sfr_pkg::*;

    sfr_state_t        state_reg, state_next;

    logic [CFG_W-1:0]  pattern_reg, pattern_next;
    logic [LEN_W-1:0]  plen_cfg_reg, plen_cfg_next;
    logic [CFG_W-1:0]  repl_reg, repl_next;
    logic [LEN_W-1:0]  rlen_cfg_reg, rlen_cfg_next;

    logic [BYTE_W-1:0] win_reg [MAX_LEN];
    logic [BYTE_W-1:0] win_next [MAX_LEN];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              last_reg, last_next;
    logic              emitted_reg, emitted_next;

    logic              pend_valid_reg, pend_valid_next;
    logic              pend_final_reg, pend_final_next;
    logic [BYTE_W-1:0] pend_char_reg, pend_char_next;
    logic              pend_cv_reg, pend_cv_next;
    logic              pend_end_reg, pend_end_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_char_reg, out_char_next;
    logic              out_cv_reg, out_cv_next;
    logic              out_end_reg, out_end_next;

    logic [CNT_W-1:0]  plen;
    logic [CNT_W-1:0]  rlen;
    logic              accept;
    logic              cnt_zero;
    logic              bytes_ok;
    logic              is_prefix;
    logic              full_match;
    logic              out_free;
    logic              slot;
    logic              want_emit;
    logic              emit_now;
    logic              move;
    logic              repl_last;

    assign plen       = clamp_len(plen_cfg_reg);
    assign rlen       = clamp_len(rlen_cfg_reg);
    assign accept     = in_ch.valid && in_ch.ready;
    assign cnt_zero   = (count_reg == '0);
    assign full_match = (plen != '0) && (count_reg == plen);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign slot       = !pend_valid_reg || out_free;
    assign emit_now   = want_emit && slot;
    assign move       = pend_valid_reg && out_free && (pend_final_reg || emit_now);
    assign repl_last  = (CNT_W'(idx_reg) == (rlen - CNT_W'(1)));

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.char_out   = out_char_reg;
    assign out_ch.char_valid = out_cv_reg;
    assign out_ch.string_end = out_end_reg;

    // window against pattern, held entries only
    always_comb
    begin
        bytes_ok = 1'b1;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (win_reg[i] != pattern_reg[i*BYTE_W +: BYTE_W]))
                bytes_ok = 1'b0;
        end
        is_prefix = (plen != '0) && (count_reg <= plen) && bytes_ok;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  want_emit = 1'b0;
            ST_SCAN:  want_emit = !cnt_zero && !is_prefix;
            ST_REPL:  want_emit = 1'b1;
            ST_FLUSH: want_emit = !cnt_zero;
            ST_DONE:  want_emit = !emitted_reg && last_reg;
            default:  want_emit = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_zero || is_prefix)
                begin
                    if (full_match && (rlen != '0))
                        state_next = ST_REPL;
                    else if (last_reg)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_REPL:
            begin
                if (emit_now && repl_last)
                    state_next = last_reg ? ST_FLUSH : ST_DONE;
            end
            ST_FLUSH:
            begin
                if (cnt_zero)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (emitted_reg || !last_reg || emit_now)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result staging
    always_comb
    begin
        pattern_next    = pattern_reg;
        plen_cfg_next   = plen_cfg_reg;
        repl_next       = repl_reg;
        rlen_cfg_next   = rlen_cfg_reg;
        win_next        = win_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        emitted_next    = emitted_reg;
        pend_valid_next = pend_valid_reg;
        pend_final_next = pend_final_reg;
        pend_char_next  = pend_char_reg;
        pend_cv_next    = pend_cv_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_cv_next     = out_cv_reg;
        out_end_next    = out_end_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:      pattern_next  = cfg_data;
                CFG_PATTERN_LENGTH:     plen_cfg_next = cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  repl_next     = cfg_data;
                CFG_REPLACEMENT_LENGTH: rlen_cfg_next = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end

        // staged result moves on to the output register
        if (move)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = pend_char_reg;
            out_cv_next     = pend_cv_reg;
            out_end_next    = pend_end_reg;
            pend_valid_next = 1'b0;
        end
        else if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    win_next[count_reg[IDX_W-1:0]] = in_ch.char_in;
                    count_next   = count_reg + CNT_W'(1);
                    last_next    = in_ch.final_char;
                    emitted_next = 1'b0;
                end
            end
            ST_SCAN, ST_FLUSH:
            begin
                if (emit_now)
                begin
                    pend_char_next = win_reg[0];
                    for (int i = 0; i < MAX_LEN - 1; i++)
                        win_next[i] = win_reg[i+1];
                    count_next = count_reg - CNT_W'(1);
                end
                else if ((state_reg == ST_SCAN) && full_match && is_prefix)
                begin
                    count_next = '0;
                    idx_next   = '0;
                end
            end
            ST_REPL:
            begin
                if (emit_now)
                begin
                    pend_char_next = repl_reg[idx_reg*BYTE_W +: BYTE_W];
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (emitted_reg)
                begin
                    pend_final_next = 1'b1;
                    pend_end_next   = last_reg;
                end
                else if (emit_now)
                begin
                    pend_char_next = '0;
                end
            end
            default: ;
        endcase

        if (emit_now)
        begin
            pend_valid_next = 1'b1;
            emitted_next    = 1'b1;
            if (state_reg == ST_DONE)
            begin
                // empty end marker
                pend_cv_next    = 1'b0;
                pend_end_next   = 1'b1;
                pend_final_next = 1'b1;
            end
            else
            begin
                pend_cv_next    = 1'b1;
                pend_end_next   = 1'b0;
                pend_final_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pattern_reg    <= '0;
            plen_cfg_reg   <= '0;
            repl_reg       <= '0;
            rlen_cfg_reg   <= '0;
            count_reg      <= '0;
            emitted_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pattern_reg    <= pattern_next;
            plen_cfg_reg   <= plen_cfg_next;
            repl_reg       <= repl_next;
            rlen_cfg_reg   <= rlen_cfg_next;
            count_reg      <= count_next;
            emitted_reg    <= emitted_next;
            pend_valid_reg <= pend_valid_next;
            pend_final_reg <= pend_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        pend_char_reg <= pend_char_next;
        pend_cv_reg   <= pend_cv_next;
        pend_end_reg  <= pend_end_next;
        out_char_reg  <= out_char_next;
        out_cv_reg    <= out_cv_next;
        out_end_reg   <= out_end_next;
    end

    // window always has room for the incoming byte
    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (count_reg < CNT_W'(MAX_LEN)))
        else $error("hold window full at accept");

    a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("sequencer did not start scan after accept");

    // an open result never waits while the block takes new bytes
    a_pend_closed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && pend_valid_reg) |-> pend_final_reg)
        else $error("staged result not closed in idle");

    a_repl_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPL) |-> (count_reg == '0))
        else $error("window not cleared during replacement");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && emitted_reg) |=> (pend_valid_reg && pend_final_reg))
        else $error("last result of transaction not closed");

endmodule

// ----- bench/sfr_substitution_checker.sv -----
`timescale 1ns / 1ps

module sfr_substitution_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  sfr_pkg::cfg_idx_t         cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0] cfg_data,
    sfr_in_if                         in_ch,
    sfr_out_if                        out_ch,
    output int                        fail_count,
    output int                        backlog
);
    import sfr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] chr;
        logic              has_char;
        logic              is_end;
    } out_char_t;

    out_char_t         expected_chars[$];
    out_char_t         head;
    logic [BYTE_W-1:0] window[MAX_LEN];
    int unsigned       held;
    logic [CFG_W-1:0]  pat;
    logic [CFG_W-1:0]  rep;
    logic [LEN_W-1:0]  pat_len;
    logic [LEN_W-1:0]  rep_len;
    int                errors;

    function automatic int unsigned sat_len(input logic [LEN_W-1:0] v);
        int unsigned r;
        r = (v > LEN_W'(MAX_LEN)) ? 32'(MAX_LEN) : 32'(v);
        return r;
    endfunction

    function automatic bit window_matches(input int unsigned plen);
        bit ok;
        ok = (plen != 0) && (held <= plen);
        for (int i = 0; i < MAX_LEN; i++)
            if (ok && i < held && window[i] != pat[8*i +: 8])
                ok = 0;
        return ok;
    endfunction

    function automatic logic [BYTE_W-1:0] pop_window();
        logic [BYTE_W-1:0] front;
        front = window[0];
        for (int i = 0; i < MAX_LEN - 1; i++)
            window[i] = window[i+1];
        held--;
        return front;
    endfunction

    // expected output characters for one accepted input character
    task automatic substitute_char(input logic [BYTE_W-1:0] c, input logic fin);
        out_char_t   batch[0:31];
        int          n;
        int unsigned plen;
        int unsigned rlen;
        n = 0;
        plen = sat_len(pat_len);
        rlen = sat_len(rep_len);
        while (held >= MAX_LEN)
        begin
            batch[n].chr = pop_window();
            batch[n].has_char = 1'b1;
            batch[n].is_end = 1'b0;
            n++;
        end
        window[held] = c;
        held++;
        while (held > 0 && !window_matches(plen))
        begin
            batch[n].chr = pop_window();
            batch[n].has_char = 1'b1;
            batch[n].is_end = 1'b0;
            n++;
        end
        if (plen > 0 && held == plen)
        begin
            for (int i = 0; i < rlen; i++)
            begin
                batch[n].chr = rep[8*i +: 8];
                batch[n].has_char = 1'b1;
                batch[n].is_end = 1'b0;
                n++;
            end
            held = 0;
        end
        if (fin)
        begin
            while (held > 0)
            begin
                batch[n].chr = pop_window();
                batch[n].has_char = 1'b1;
                batch[n].is_end = 1'b0;
                n++;
            end
            if (n == 0)
            begin
                batch[0].chr = '0;
                batch[0].has_char = 1'b0;
                n = 1;
            end
            batch[n-1].is_end = 1'b1;
        end
        for (int i = 0; i < n; i++)
            expected_chars.push_back(batch[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            held = 0;
            pat = '0;
            rep = '0;
            pat_len = '0;
            rep_len = '0;
            errors = 0;
            fail_count <= 0;
            backlog <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_BYTES:      pat = cfg_data;
                    CFG_PATTERN_LENGTH:     pat_len = cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  rep = cfg_data;
                    CFG_REPLACEMENT_LENGTH: rep_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                substitute_char(in_ch.char_in, in_ch.final_char);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected output transaction: char_out %0h", out_ch.char_out);
                    errors++;
                end
                else
                begin
                    head = expected_chars.pop_front();
                    if (out_ch.char_out !== head.chr)
                    begin
                        $error("char_out expected %0h actual %0h", head.chr, out_ch.char_out);
                        errors++;
                    end
                    if (out_ch.char_valid !== head.has_char)
                    begin
                        $error("char_valid expected %0b actual %0b",
                               head.has_char, out_ch.char_valid);
                        errors++;
                    end
                    if (out_ch.string_end !== head.is_end)
                    begin
                        $error("string_end expected %0b actual %0b",
                               head.is_end, out_ch.string_end);
                        errors++;
                    end
                end
            end
            fail_count <= errors;
            backlog <= expected_chars.size();
        end
    end

endmodule

// ----- bench/stream_find_replace_unit_tb.sv -----
`timescale 1ns / 1ps

module stream_find_replace_unit_tb;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 28;
    localparam int PHASES        = 7;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    sfr_in_if  in_ch();
    sfr_out_if out_ch();

    int fail_count;
    int backlog;
    int cycles = 0;

    bit                src_gaps;
    bit                sink_stall;
    int                stall_left = 0;
    int                roll;
    logic [BYTE_W-1:0] alpha[3];
    logic [CFG_W-1:0]  pat_now;
    int                pat_eff;
    int                str_left = 0;
    int                insert_left = 0;
    int                insert_pos = 0;
    logic [LEN_W-1:0]  pl;
    logic [LEN_W-1:0]  rl;
    logic [CFG_W-1:0]  pb;

    stream_find_replace_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    sfr_substitution_checker sub_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("stream_find_replace_unit verification failed");
            $finish;
        end
    end

    // output back-pressure
    always @(posedge clk)
    begin
        if (!sink_stall)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                out_ch.ready <= 1'b1;
            else if (roll < 93)
            begin
                out_ch.ready <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_ch.ready <= 1'b0;
                stall_left <= $urandom_range(9, 29);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!src_gaps || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_char(input logic [BYTE_W-1:0] c, input logic fin);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.char_in <= c;
        in_ch.final_char <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] pbytes, input logic [LEN_W-1:0] plen,
                               input logic [CFG_W-1:0] rbytes, input logic [LEN_W-1:0] rlen);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_data <= pbytes;
        @(posedge clk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data <= CFG_W'(plen);
        @(posedge clk);
        cfg_index <= CFG_REPLACEMENT_BYTES;
        cfg_data <= rbytes;
        @(posedge clk);
        cfg_index <= CFG_REPLACEMENT_LENGTH;
        cfg_data <= CFG_W'(rlen);
        @(posedge clk);
        cfg_we <= 1'b0;
        pat_now = pbytes;
        pat_eff = (plen > LEN_W'(MAX_LEN)) ? MAX_LEN : int'(plen);
    endtask

    // mostly pattern fragments, whole or cut short, over a small alphabet
    task automatic random_char();
        logic [BYTE_W-1:0] c;
        int                r;
        if (str_left == 0)
            str_left = $urandom_range(1, 16);
        if (insert_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 35 && pat_eff > 0)
            begin
                insert_pos = 0;
                insert_left = (r < 26) ? pat_eff : $urandom_range(1, pat_eff);
            end
        end
        if (insert_left > 0)
        begin
            c = pat_now[8*insert_pos +: 8];
            insert_pos++;
            insert_left--;
        end
        else if ($urandom_range(0, 99) < 75)
            c = alpha[$urandom_range(0, 2)];
        else
            c = BYTE_W'($urandom_range(0, 255));
        str_left--;
        push_char(c, str_left == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PATTERN_BYTES;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.char_in = '0;
        in_ch.final_char = 1'b0;
        src_gaps = 1'b0;
        sink_stall = 1'b1;
        pat_now = '0;
        pat_eff = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through with reset configuration
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);

        // "ab" -> "XYZ", overlapping start
        settle();
        load_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        push_char(8'h61, 1'b0);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b0);
        push_char(8'h63, 1'b1);

        // deletion leaves only the empty end marker
        settle();
        load_config(64'h6261, 4'd2, 64'h5A5958, 4'd0);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b1);

        // zero bytes in pattern, both lengths saturating
        settle();
        load_config('0, 4'd15, '1, 4'd9);
        repeat (7) push_char(8'h00, 1'b0);
        push_char(8'h00, 1'b1);

        // pattern swapped while bytes are held
        settle();
        load_config(64'h636261, 4'd3, 64'h51, 4'd1);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b0);
        settle();
        load_config(64'h7978, 4'd2, 64'h51, 4'd1);
        push_char(8'h63, 1'b1);

        // single-byte pattern, longest replacement
        settle();
        load_config(64'h61, 4'd1, 64'h0123456789ABCDEF, 4'd8);
        push_char(8'h61, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            for (int k = 0; k < 3; k++)
                alpha[k] = BYTE_W'($urandom_range(0, 255));
            if (ph == 0)
            begin
                alpha[0] = 8'h00;
                alpha[1] = 8'hFF;
            end
            for (int k = 0; k < MAX_LEN; k++)
                pb[8*k +: 8] = alpha[$urandom_range(0, 2)];
            case (ph)
                0: begin pl = 4'd8; rl = 4'd8; end
                1: begin pl = 4'd0; rl = LEN_W'($urandom_range(0, 15)); end
                2: begin pl = 4'd1; rl = 4'd0; end
                3: begin pl = 4'd15; rl = 4'd15; end
                6:
                begin
                    pl = LEN_W'($urandom_range(0, 15));
                    rl = LEN_W'($urandom_range(0, 15));
                end
                default:
                begin
                    pl = LEN_W'($urandom_range(1, 4));
                    rl = LEN_W'($urandom_range(0, 15));
                end
            endcase
            insert_left = 0;
            load_config(pb, pl, {$urandom, $urandom}, rl);
            src_gaps = (ph != 0) && ($urandom_range(0, 4) != 0);
            sink_stall = (ph == 1) || ((ph != 0) && ($urandom_range(0, 3) != 0));
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_char();
        end

        // close any open string
        if (str_left > 0)
        begin
            str_left = 1;
            random_char();
        end
        settle();
        if (fail_count == 0 && backlog == 0)
            $display("stream_find_replace_unit verification clean");
        else
            $display("stream_find_replace_unit verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sfr_pkg.sv
hdl/sfr_in_if.sv
hdl/sfr_out_if.sv
hdl/stream_find_replace_unit.sv
bench/sfr_substitution_checker.sv
bench/stream_find_replace_unit_tb.sv
